@@ src/acpu_pkg.sv @@
// Shared types and constants for the accumulator CPU execute core.
// No dependencies; every other file refers to this package by scoped names.

package acpu_pkg;

   localparam int DataWidth      = 8;
   localparam int MemDepthDefault = 256;
   localparam logic [DataWidth-1:0] StackLimitReset = 8'd224;
   localparam int RspQueueDepth  = 3;
   localparam int RspCountWidth  = $clog2(RspQueueDepth + 1);
   localparam int RspPtrWidth    = $clog2(RspQueueDepth);

   typedef enum logic [3:0] {
      OP_LDI  = 4'd0,
      OP_LDA  = 4'd1,
      OP_STA  = 4'd2,
      OP_MOV  = 4'd3,
      OP_ADD  = 4'd4,
      OP_SUB  = 4'd5,
      OP_CMP  = 4'd6,
      OP_JMP  = 4'd7,
      OP_JNE  = 4'd8,
      OP_PUSH = 4'd9,
      OP_POP  = 4'd10,
      OP_HLT  = 4'd11
   } op_type;

   typedef enum logic [1:0] {
      SRC_REG_A = 2'd0,
      SRC_REG_B = 2'd1,
      SRC_IMM   = 2'd2
   } src_type;

   typedef enum logic [1:0] {
      STAT_RUN       = 2'd0,
      STAT_HALT      = 2'd1,
      STAT_OVERFLOW  = 2'd2,
      STAT_UNDERFLOW = 2'd3
   } status_type;

   localparam logic DestRegA = 1'b0;

   // Architectural state, also the payload of one result.
   typedef struct packed {
      logic [DataWidth-1:0] pc;
      logic [DataWidth-1:0] reg_a;
      logic [DataWidth-1:0] reg_b;
      logic                 zero;
      logic                 carry;
      logic [DataWidth-1:0] sp;
      status_type           stop;
   } state_type;

   typedef struct packed {
      logic [3:0]           operation;
      logic                 dest_reg;
      logic [1:0]           source_kind;
      logic [DataWidth-1:0] immediate;
      logic [DataWidth-1:0] jump_target;
   } req_type;

   // Memory access requested by one instruction; addr is already reduced
   // to the memory depth.
   typedef struct packed {
      logic                 rd_en;
      logic                 wr_en;
      logic [DataWidth-1:0] addr;
      logic [DataWidth-1:0] wr_data;
      logic                 load;
      logic                 load_dest;
   } mem_op_type;

endpackage

@@ src/acpu_req_if.sv @@
// Request channel of the accumulator CPU execute core.
// Depends on acpu_pkg for the data width.

interface acpu_req_if;
   logic                          valid;
   logic                          ready;
   logic [3:0]                    operation;
   logic                          dest_reg;
   logic [1:0]                    source_kind;
   logic [acpu_pkg::DataWidth-1:0] immediate;
   logic [acpu_pkg::DataWidth-1:0] jump_target;

   modport source (
      output valid, operation, dest_reg, source_kind, immediate, jump_target,
      input  ready
   );
   modport sink (
      input  valid, operation, dest_reg, source_kind, immediate, jump_target,
      output ready
   );
endinterface

@@ src/acpu_rsp_if.sv @@
// Result channel of the accumulator CPU execute core.
// Depends on acpu_pkg for the data width.

interface acpu_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [acpu_pkg::DataWidth-1:0] next_pc;
   logic [acpu_pkg::DataWidth-1:0] reg_a_out;
   logic [acpu_pkg::DataWidth-1:0] reg_b_out;
   logic                          zero_out;
   logic                          carry_out;
   logic [acpu_pkg::DataWidth-1:0] stack_ptr_out;
   logic [1:0]                    status;

   modport source (
      output valid, next_pc, reg_a_out, reg_b_out, zero_out, carry_out,
             stack_ptr_out, status,
      input  ready
   );
   modport sink (
      input  valid, next_pc, reg_a_out, reg_b_out, zero_out, carry_out,
             stack_ptr_out, status,
      output ready
   );
endinterface

@@ src/accumulator_cpu_execute_core.sv @@
// Top level of the accumulator CPU execute core: state registers, data
// memory with valid bits, load forwarding. Uses acpu_pkg, acpu_req_if,
// acpu_rsp_if, acpu_exec and acpu_rsp_queue.
//
//   Channel  Direction  Handshake           Carries
//   req_bus  in         valid/ready         one decoded instruction
//   rsp_bus  out        valid/ready         state and status after it
//   csr_*    in         write enable only   stack_limit
//
// One request is accepted per cycle while ready; its result is registered
// in state_ff, then in the result queue, before it is offered. Loads read
// the data memory at the accept edge, and the registered read data is
// forwarded to the next request in the following cycle. Reset clears the
// registers and the memory valid bits at once, so requests are taken in
// the first cycle after reset. The request side stalls only when the
// three-entry result queue plus the result in flight would overflow.

module accumulator_cpu_execute_core #(
   parameter int MEM_DEPTH = acpu_pkg::MemDepthDefault
) (
   input  logic                           clock,
   input  logic                           reset,
   acpu_req_if.sink                       req_bus,
   acpu_rsp_if.source                     rsp_bus,
   input  logic                           csr_write_en,
   input  logic [acpu_pkg::DataWidth-1:0] csr_write_data
);

   localparam int AW = $clog2(MEM_DEPTH);
   localparam int DW = acpu_pkg::DataWidth;
   localparam int CW = acpu_pkg::RspCountWidth;

   logic [DW-1:0]        stack_limit_ff;
   acpu_pkg::state_type  state_ff, state_in;
   acpu_pkg::state_type  cur;
   acpu_pkg::state_type  nxt;
   acpu_pkg::req_type    req;
   acpu_pkg::mem_op_type mem_op;

   logic [DW-1:0]        mem [MEM_DEPTH];
   logic [MEM_DEPTH-1:0] mem_valid_ff;
   logic [DW-1:0]        rd_data_ff;
   logic                 rd_valid_ff;
   logic                 ld_pend_ff;
   logic                 ld_dest_ff;
   logic                 s2_valid_ff;
   logic [DW-1:0]        ld_data;
   logic [AW-1:0]        mem_addr;
   logic [CW:0]          occupancy;
   logic [CW-1:0]        rsp_count;
   logic                 accept;

   assign req.operation   = req_bus.operation;
   assign req.dest_reg    = req_bus.dest_reg;
   assign req.source_kind = req_bus.source_kind;
   assign req.immediate   = req_bus.immediate;
   assign req.jump_target = req_bus.jump_target;

   assign occupancy     = {1'b0, rsp_count} + (CW+1)'(s2_valid_ff);
   assign req_bus.ready = (occupancy < (CW+1)'(acpu_pkg::RspQueueDepth));
   assign accept        = req_bus.valid && req_bus.ready;

   // An entry never written since reset reads as zero.
   assign ld_data = rd_valid_ff ? rd_data_ff : '0;

   always_comb begin
      cur = state_ff;
      if (ld_pend_ff) begin
         if (ld_dest_ff == acpu_pkg::DestRegA) cur.reg_a = ld_data;
         else cur.reg_b = ld_data;
      end
   end

   acpu_exec #(
      .MEM_DEPTH (MEM_DEPTH)
   ) u_exec (
      .cur         (cur),
      .req         (req),
      .stack_limit (stack_limit_ff),
      .nxt         (nxt),
      .mem_op      (mem_op)
   );

   assign state_in = accept ? nxt : cur;
   assign mem_addr = mem_op.addr[AW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         stack_limit_ff <= acpu_pkg::StackLimitReset;
         state_ff       <= '{pc: '0, reg_a: '0, reg_b: '0, zero: 1'b0, carry: 1'b0,
                             sp: DW'(MEM_DEPTH - 1), stop: acpu_pkg::STAT_RUN};
         mem_valid_ff   <= '0;
         ld_pend_ff     <= 1'b0;
         ld_dest_ff     <= 1'b0;
         s2_valid_ff    <= 1'b0;
      end else begin
         if (csr_write_en) stack_limit_ff <= csr_write_data;
         state_ff    <= state_in;
         ld_pend_ff  <= accept && mem_op.load;
         ld_dest_ff  <= mem_op.load_dest;
         s2_valid_ff <= accept;
         if (accept && mem_op.wr_en) mem_valid_ff[mem_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && mem_op.wr_en) mem[mem_addr] <= mem_op.wr_data;
      if (accept && mem_op.rd_en) begin
         rd_data_ff  <= mem[mem_addr];
         rd_valid_ff <= mem_valid_ff[mem_addr];
      end
   end

   // The state seen in the cycle after acceptance, with any load applied,
   // is the result of that request.
   acpu_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (s2_valid_ff),
      .push_data (cur),
      .rsp_bus   (rsp_bus),
      .count     (rsp_count)
   );

endmodule

@@ src/acpu_exec.sv @@
// Instruction execute logic: next architectural state and memory access.
// Depends on acpu_pkg; purely combinational.

module acpu_exec #(
   parameter int MEM_DEPTH = acpu_pkg::MemDepthDefault
) (
   input  acpu_pkg::state_type  cur,
   input  acpu_pkg::req_type    req,
   input  logic [acpu_pkg::DataWidth-1:0] stack_limit,
   output acpu_pkg::state_type  nxt,
   output acpu_pkg::mem_op_type mem_op
);

   localparam int AW = $clog2(MEM_DEPTH);
   localparam int DW = acpu_pkg::DataWidth;
   localparam int TableSize = 1 << DW;

   typedef logic [AW-1:0] mod_table_type [TableSize];

   // Address reduction modulo the memory depth, built by counting.
   function automatic mod_table_type build_mod_table();
      mod_table_type tbl;
      int unsigned   r;
      r = 0;
      for (int i = 0; i < TableSize; i++) begin
         tbl[i] = AW'(r);
         r = (r + 1 == MEM_DEPTH) ? 0 : r + 1;
      end
      return tbl;
   endfunction

   localparam mod_table_type ModTable = build_mod_table();

   logic [DW-1:0] val;
   logic [DW-1:0] npc;
   logic [DW:0]   sum;
   logic [DW:0]   diff;
   logic [DW:0]   sp_inc;
   logic [DW-1:0] sp_dec;

   always_comb begin
      case (acpu_pkg::src_type'(req.source_kind))
         acpu_pkg::SRC_REG_A: val = cur.reg_a;
         acpu_pkg::SRC_REG_B: val = cur.reg_b;
         default:             val = req.immediate;
      endcase
   end

   assign sum    = {1'b0, cur.reg_a} + {1'b0, cur.reg_b};
   assign diff   = {1'b0, cur.reg_a} - {1'b0, cur.reg_b};
   assign sp_inc = {1'b0, cur.sp} + (DW+1)'(1);
   assign sp_dec = cur.sp - DW'(1);

   always_comb begin
      nxt    = cur;
      mem_op = '0;
      npc    = cur.pc + DW'(1);
      if (cur.stop == acpu_pkg::STAT_RUN) begin
         unique case (acpu_pkg::op_type'(req.operation))
            acpu_pkg::OP_LDI, acpu_pkg::OP_MOV: begin
               if (req.dest_reg == acpu_pkg::DestRegA) nxt.reg_a = val;
               else nxt.reg_b = val;
            end
            acpu_pkg::OP_LDA: begin
               mem_op.rd_en     = 1'b1;
               mem_op.addr      = DW'(ModTable[val]);
               mem_op.load      = 1'b1;
               mem_op.load_dest = acpu_pkg::DestRegA;
            end
            acpu_pkg::OP_STA: begin
               mem_op.wr_en   = 1'b1;
               mem_op.addr    = DW'(ModTable[val]);
               mem_op.wr_data = cur.reg_a;
            end
            acpu_pkg::OP_ADD: begin
               nxt.reg_a = sum[DW-1:0];
               nxt.carry = sum[DW];
               nxt.zero  = (sum[DW-1:0] == '0);
            end
            acpu_pkg::OP_SUB: begin
               // The borrow out of the 9-bit difference is old B > old A.
               nxt.reg_a = diff[DW-1:0];
               nxt.carry = diff[DW];
               nxt.zero  = (diff[DW-1:0] == '0);
            end
            acpu_pkg::OP_CMP: begin
               nxt.zero  = (cur.reg_a == cur.reg_b);
               nxt.carry = diff[DW];
            end
            acpu_pkg::OP_JMP: npc = req.jump_target;
            acpu_pkg::OP_JNE: begin
               if (!cur.zero) npc = req.jump_target;
            end
            acpu_pkg::OP_PUSH: begin
               mem_op.wr_en   = 1'b1;
               mem_op.addr    = DW'(ModTable[cur.sp]);
               mem_op.wr_data = val;
               nxt.sp         = sp_dec;
               if (cur.sp == '0 || sp_dec < stack_limit) begin
                  nxt.stop = acpu_pkg::STAT_OVERFLOW;
                  npc      = cur.pc;
               end
            end
            acpu_pkg::OP_POP: begin
               if (sp_inc > (DW+1)'(MEM_DEPTH - 1)) begin
                  nxt.stop = acpu_pkg::STAT_UNDERFLOW;
                  npc      = cur.pc;
               end else begin
                  // The incremented pointer is below the depth here.
                  nxt.sp           = sp_inc[DW-1:0];
                  mem_op.rd_en     = 1'b1;
                  mem_op.addr      = sp_inc[DW-1:0];
                  mem_op.load      = 1'b1;
                  mem_op.load_dest = req.dest_reg;
               end
            end
            acpu_pkg::OP_HLT: begin
               nxt.stop = acpu_pkg::STAT_HALT;
               npc      = cur.pc;
            end
            default: ;
         endcase
         nxt.pc = npc;
      end
   end

endmodule

@@ src/acpu_rsp_queue.sv @@
// Result queue of the accumulator CPU execute core: a small FIFO that
// drives the result channel. Depends on acpu_pkg and acpu_rsp_if.

module acpu_rsp_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  acpu_pkg::state_type push_data,
   acpu_rsp_if.source          rsp_bus,
   output logic [acpu_pkg::RspCountWidth-1:0] count
);

   localparam int Depth = acpu_pkg::RspQueueDepth;
   localparam int PW    = acpu_pkg::RspPtrWidth;
   localparam int CW    = acpu_pkg::RspCountWidth;

   acpu_pkg::state_type entry_ff [Depth];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          pop;
   acpu_pkg::state_type head;

   assign pop = rsp_bus.valid && rsp_bus.ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(Depth - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(Depth - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + CW'(1);
         2'b01:   count_in = count_ff - CW'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= push_data;
   end

   assign head  = entry_ff[rd_ptr_ff];
   assign count = count_ff;

   assign rsp_bus.valid         = (count_ff != '0);
   assign rsp_bus.next_pc       = head.pc;
   assign rsp_bus.reg_a_out     = head.reg_a;
   assign rsp_bus.reg_b_out     = head.reg_b;
   assign rsp_bus.zero_out      = head.zero;
   assign rsp_bus.carry_out     = head.carry;
   assign rsp_bus.stack_ptr_out = head.sp;
   assign rsp_bus.status        = head.stop;

endmodule

@@ src/acpu_checker.sv @@
// Port-level checks for the accumulator CPU execute core, attached to the
// top level with a bind statement. Depends on acpu_pkg.

module acpu_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [acpu_pkg::DataWidth-1:0] rsp_next_pc,
   input logic [1:0]                     rsp_status
);

   logic       req_acc;
   logic       rsp_acc;
   logic [2:0] inflight_ff;
   logic       stopped_ff;
   logic [1:0] stop_status_ff;
   logic [acpu_pkg::DataWidth-1:0] stop_pc_ff;

   assign req_acc = req_valid && req_ready;
   assign rsp_acc = rsp_valid && rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         inflight_ff    <= '0;
         stopped_ff     <= 1'b0;
         stop_status_ff <= '0;
         stop_pc_ff     <= '0;
      end else begin
         inflight_ff <= inflight_ff + 3'(req_acc) - 3'(rsp_acc);
         if (rsp_acc && !stopped_ff && rsp_status != acpu_pkg::STAT_RUN) begin
            stopped_ff     <= 1'b1;
            stop_status_ff <= rsp_status;
            stop_pc_ff     <= rsp_next_pc;
         end
      end
   end

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result offered right after reset");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> inflight_ff != 3'd0)
      else $error("result offered with no request outstanding");

   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_acc && inflight_ff == 3'd0 |-> ##2 rsp_valid)
      else $error("result of an idle-time request not offered after two cycles");

   a_stop_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && stopped_ff |-> rsp_status == stop_status_ff && rsp_next_pc == stop_pc_ff)
      else $error("stopped core changed its status or program counter");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_next_pc) && $stable(rsp_status))
      else $error("stalled result dropped or changed");

endmodule

bind accumulator_cpu_execute_core acpu_checker u_acpu_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_bus.valid),
   .req_ready   (req_bus.ready),
   .rsp_valid   (rsp_bus.valid),
   .rsp_ready   (rsp_bus.ready),
   .rsp_next_pc (rsp_bus.next_pc),
   .rsp_status  (rsp_bus.status)
);
